@@ hw/rtl/slr_pkg.sv @@
// Package for the shuffled Lehmer random generator.
// Holds widths and generator constants; no dependencies.
`default_nettype none

package slr_pkg;

  // Data widths
  localparam int VALUE_W = 31;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = VALUE_W + MULT_W;

  // Park-Miller minimal standard constants
  localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] LCG_ONE  = 31'd1;

  // Extra warm-up steps beyond the table size, less one
  localparam int WARMUP_EXTRA = 7;

  // Default number of shuffle table entries
  localparam int DEF_TABLE_ENTRIES = 32;

endpackage

`default_nettype wire

@@ hw/rtl/slr_req_if.sv @@
// Request channel of the shuffled Lehmer random generator.
// Depends on slr_pkg for the seed width.
`default_nettype none

interface slr_req_if;

  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [slr_pkg::VALUE_W-1:0] seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink (input valid, input op, input seed_value, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/slr_rsp_if.sv @@
// Result channel of the shuffled Lehmer random generator.
// Depends on slr_pkg for the value width.
`default_nettype none

interface slr_rsp_if;

  logic                        valid;
  logic                        ready;
  logic [slr_pkg::VALUE_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/shuffled_lehmer_random.sv @@
// Shuffled Lehmer random generator: Park-Miller minimal standard step with a
// Bays-Durham shuffle table. Each request returns one 31-bit value in
// 1 .. 2^31-2. A plain draw steps through the issue, wait, read and result
// states, waiting in the last while the output register is full, and the
// next request is taken once the block is back in idle. The draw runs the
// two-stage multiply and reduce unit (the table index is worked out alongside
// it), followed by one table read and one table write. A reseed, and the
// first draw after reset, first runs TABLE_ENTRIES+8 generator steps through
// the same multiply and reduce unit. A seed of 0 or 2^31-1 is taken as 1.
// The block takes one request at a time; a finished result waits in an
// output register while the next request is taken.
// Depends on slr_pkg, slr_req_if, slr_rsp_if, slr_lcg_unit, slr_slot_div.
`default_nettype none

module shuffled_lehmer_random #(
  parameter int TABLE_ENTRIES = slr_pkg::DEF_TABLE_ENTRIES
) (
  input wire logic clk,
  input wire logic rst,
  slr_req_if.sink   req,
  slr_rsp_if.source rsp
);

  localparam int IdxW  = $clog2(TABLE_ENTRIES);
  localparam int FillN = TABLE_ENTRIES + slr_pkg::WARMUP_EXTRA;
  localparam int CntW  = $clog2(FillN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_FILL_WAIT,
    S_DRAW_ISSUE,
    S_DRAW_WAIT,
    S_READ,
    S_RESULT
  } state_t;

  state_t                      state;
  logic [slr_pkg::VALUE_W-1:0] lcg;
  logic [slr_pkg::VALUE_W-1:0] last;
  logic                        init;
  logic [CntW-1:0]             fill_cnt;
  logic [slr_pkg::VALUE_W-1:0] out_value;
  logic                        out_valid;
  logic                        out_free;
  logic [slr_pkg::VALUE_W-1:0] seed_fixed;

  logic                        lcg_start;
  logic                        lcg_done;
  logic [slr_pkg::VALUE_W-1:0] lcg_y;
  logic                        div_done;
  logic [IdxW-1:0]             slot;

  logic [slr_pkg::VALUE_W-1:0] tbl [TABLE_ENTRIES];
  logic [slr_pkg::VALUE_W-1:0] tbl_rdata;
  logic                        tbl_we;
  logic [IdxW-1:0]             tbl_waddr;
  logic [slr_pkg::VALUE_W-1:0] tbl_wdata;

  // Handshake and seed cleanup
  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;
  assign out_free         = !out_valid || rsp.ready;
  assign seed_fixed = ((req.seed_value == '0) || (req.seed_value == slr_pkg::LCG_MOD))
                    ? slr_pkg::LCG_ONE : req.seed_value;

  assign lcg_start = (state == S_FILL) || (state == S_DRAW_ISSUE);

  // Shared multiply and reduce unit
  slr_lcg_unit u_lcg (
    .clk   (clk),
    .rst   (rst),
    .start (lcg_start),
    .x     (lcg),
    .done  (lcg_done),
    .y     (lcg_y)
  );

  // Table index from the previous output
  slr_slot_div #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DRAW_ISSUE),
    .dividend (last),
    .done     (div_done),
    .slot     (slot)
  );

  // Table write port: warm-up fill or replacement of the drawn entry
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot;
    tbl_wdata = lcg_y;
    if (state == S_FILL_WAIT) begin
      tbl_waddr = fill_cnt[IdxW-1:0];
      tbl_we    = lcg_done && (fill_cnt < CntW'(TABLE_ENTRIES));
    end else if (state == S_RESULT) begin
      tbl_we = out_free;
    end
  end

  // Shuffle table with registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
    if (state == S_READ) begin
      tbl_rdata <= tbl[slot];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lcg       <= slr_pkg::LCG_ONE;
      init      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            fill_cnt <= CntW'(FillN);
            if (req.op) begin
              lcg   <= seed_fixed;
              state <= S_FILL;
            end else if (!init) begin
              state <= S_FILL;
            end else begin
              state <= S_DRAW_ISSUE;
            end
          end
        end
        S_FILL: begin
          state <= S_FILL_WAIT;
        end
        S_FILL_WAIT: begin
          if (lcg_done) begin
            lcg <= lcg_y;
            if (fill_cnt == '0) begin
              last  <= lcg_y;
              init  <= 1'b1;
              state <= S_DRAW_ISSUE;
            end else begin
              fill_cnt <= fill_cnt - 1'b1;
              state    <= S_FILL;
            end
          end
        end
        S_DRAW_ISSUE: begin
          state <= S_DRAW_WAIT;
        end
        S_DRAW_WAIT: begin
          // The table index is ready before the generator step finishes
          if (lcg_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          // Hold until the output register is free
          if (out_free) begin
            lcg       <= lcg_y;
            last      <= tbl_rdata;
            out_value <= tbl_rdata;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_init_nonzero : assert property (@(posedge clk) disable iff (rst)
    init |-> last != '0)
    else $error("initialized with a zero previous output");

  a_div_in_wait : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DRAW_WAIT)
    else $error("slot index finished outside the draw wait");

  a_lcg_origin : assert property (@(posedge clk) disable iff (rst)
    lcg_done |-> ($past(state, 2) == S_FILL) || ($past(state, 2) == S_DRAW_ISSUE))
    else $error("generator step finished without a matching issue");

  a_fill_end : assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL_WAIT) && lcg_done && (fill_cnt == '0) |=>
      init && (state == S_DRAW_ISSUE))
    else $error("warm-up end did not start a draw");

  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && out_valid && !rsp.ready |=>
      (state == S_RESULT) && $stable(tbl_rdata))
    else $error("result lost while output register was full");

endmodule

`default_nettype wire

@@ hw/rtl/slr_lcg_unit.sv @@
// Shared generator step: x * 16807 mod (2^31 - 1) in two register stages.
// Depends on slr_pkg for widths and constants.
`default_nettype none

module slr_lcg_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [slr_pkg::VALUE_W-1:0] x,
  output logic                             done,
  output logic      [slr_pkg::VALUE_W-1:0] y
);

  logic [slr_pkg::PROD_W-1:0]  prod;
  logic                        prod_valid;
  logic [slr_pkg::VALUE_W:0]   fold_sum;
  logic [slr_pkg::VALUE_W:0]   fold_diff;
  logic                        fold_ge;

  // Fold the high part back in: 2^31 is 1 modulo the modulus
  assign fold_sum  = {1'b0, prod[slr_pkg::VALUE_W-1:0]}
                   + (slr_pkg::VALUE_W + 1)'(prod[slr_pkg::PROD_W-1:slr_pkg::VALUE_W]);
  assign fold_diff = fold_sum - {1'b0, slr_pkg::LCG_MOD};
  assign fold_ge   = fold_sum >= {1'b0, slr_pkg::LCG_MOD};

  // Multiply stage
  always_ff @(posedge clk) begin
    prod <= slr_pkg::PROD_W'(slr_pkg::LCG_MULT) * slr_pkg::PROD_W'(x);
  end

  // Reduce stage
  always_ff @(posedge clk) begin
    y <= fold_ge ? fold_diff[slr_pkg::VALUE_W-1:0] : fold_sum[slr_pkg::VALUE_W-1:0];
  end

  // Step valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/slr_slot_div.sv @@
// Table index from the previous output, by compares with the constant slot bounds.
// Depends on slr_pkg for the value width; table size comes from the top.
`default_nettype none

module slr_slot_div #(
  parameter int TABLE_ENTRIES = slr_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [slr_pkg::VALUE_W-1:0]          dividend,
  output logic                                      done,
  output logic      [$clog2(TABLE_ENTRIES)-1:0]     slot
);

  localparam int          IdxW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned SlotDiv = 1 + (32'd2147483646 / TABLE_ENTRIES);

  logic [IdxW-1:0] slot_sel;

  // Pick the highest slot bound at or below the dividend; the last bound lies
  // inside the top entry, so the index never passes TABLE_ENTRIES-1
  always_comb begin
    slot_sel = '0;
    for (int k = 1; k < TABLE_ENTRIES; k++) begin
      if ({1'b0, dividend} >= 32'(k) * SlotDiv) begin
        slot_sel = IdxW'(k);
      end
    end
  end

  // Flag the index in the cycle after the start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Capture the index
  always_ff @(posedge clk) begin
    if (start) begin
      slot <= slot_sel;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for shuffled_lehmer_random: a scoreboard predicts every draw and reseed
// and checks each 31-bit result in order, with random idling on both channels.
// Depends on slr_pkg, slr_req_if, slr_rsp_if and the shuffled_lehmer_random RTL.

typedef enum logic {
  OP_DRAW   = 1'b0,
  OP_RESEED = 1'b1
} req_op_e;

class lehmer_scoreboard;

  localparam int ENTRIES = slr_pkg::DEF_TABLE_ENTRIES;
  localparam int unsigned SLOT_SPAN =
    32'd1 + (32'(slr_pkg::LCG_MOD) - 32'd1) / ENTRIES;
  localparam int MAX_PRINTED = 20;

  logic [slr_pkg::VALUE_W-1:0] gen_state;
  logic [slr_pkg::VALUE_W-1:0] prev_output;
  logic [slr_pkg::VALUE_W-1:0] shuffle_slots [ENTRIES];
  logic [slr_pkg::VALUE_W-1:0] expected_values [$];
  int err_count;
  int checked_count;
  int draw_count;
  int reseed_count;

  function new();
    gen_state     = slr_pkg::LCG_ONE;
    prev_output   = '0;
    err_count     = 0;
    checked_count = 0;
    draw_count    = 0;
    reseed_count  = 0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
  endfunction

  // One Park-Miller step on the exact 46-bit product
  function logic [slr_pkg::VALUE_W-1:0] lehmer_step(logic [slr_pkg::VALUE_W-1:0] x);
    longint unsigned prod;
    prod = 64'(slr_pkg::LCG_MULT) * 64'(x);
    return slr_pkg::VALUE_W'(prod % 64'(slr_pkg::LCG_MOD));
  endfunction

  // Run the warm-up steps, keeping the last ENTRIES values in the table
  function void warm_table();
    int k;
    for (k = ENTRIES + slr_pkg::WARMUP_EXTRA; k >= 0; k--) begin
      gen_state = lehmer_step(gen_state);
      if (k < ENTRIES) shuffle_slots[k] = gen_state;
    end
    prev_output = shuffle_slots[0];
  endfunction

  // Predict the value returned for one accepted request
  function void note_request(req_op_e op, logic [slr_pkg::VALUE_W-1:0] seed);
    logic [slr_pkg::VALUE_W-1:0] start;
    logic [slr_pkg::VALUE_W-1:0] value;
    int unsigned slot;
    if (op == OP_RESEED) begin
      start = slr_pkg::VALUE_W'(32'(seed) % 32'(slr_pkg::LCG_MOD));
      if (start == '0) start = slr_pkg::LCG_ONE;
      gen_state = start;
      warm_table();
      reseed_count++;
    end else begin
      // First draw after reset fills the table from the current state
      if (prev_output == '0) begin
        if (gen_state == '0 || gen_state >= slr_pkg::LCG_MOD) gen_state = slr_pkg::LCG_ONE;
        warm_table();
      end
      draw_count++;
    end
    gen_state = lehmer_step(gen_state);
    slot = 32'(prev_output) / SLOT_SPAN;
    if (slot >= ENTRIES) slot = ENTRIES - 1;
    value = shuffle_slots[slot];
    shuffle_slots[slot] = gen_state;
    prev_output = value;
    expected_values.push_back(value);
  endfunction

  task report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  // Compare one result transfer with the oldest prediction
  task check_value(logic [slr_pkg::VALUE_W-1:0] got);
    logic [slr_pkg::VALUE_W-1:0] want;
    if (expected_values.size() == 0) begin
      report_mismatch($sformatf("random_value %0d with no request pending", got));
    end else begin
      want = expected_values.pop_front();
      checked_count++;
      if (got !== want)
        report_mismatch($sformatf("result %0d: random_value %0d, expected %0d",
                                  checked_count, got, want));
    end
  endtask

endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 630;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 150;
  localparam int IDLE_LIMIT   = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slr_req_if req ();
  slr_rsp_if rsp ();

  lehmer_scoreboard sb;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  shuffled_lehmer_random dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input req_op_e op, input logic [slr_pkg::VALUE_W-1:0] seed);
    req.valid      <= 1'b1;
    req.op         <= op;
    req.seed_value <= seed;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, seed);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic offer(input req_op_e op, input logic [slr_pkg::VALUE_W-1:0] seed);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    send_request(op, seed);
  endtask

  // Stimulus: directed cases, then random draws with occasional reseeds
  initial begin
    int k;
    logic [slr_pkg::VALUE_W-1:0] seed;
    sb = new();
    req.valid      = 1'b0;
    req.op         = OP_DRAW;
    req.seed_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Draw before any seed, with the ignored seed field at both extremes
    send_request(OP_DRAW, '1);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, 31'h2AAA_AAAA);
    // Zero seed and a seed equal to the modulus both act as seed one
    send_request(OP_RESEED, '0);
    send_request(OP_DRAW, 31'h5555_5555);
    send_request(OP_RESEED, '1);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, slr_pkg::LCG_ONE);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, 31'h7FFF_FFFE);
    send_request(OP_DRAW, '1);
    send_request(OP_RESEED, 31'h5555_5555);
    send_request(OP_RESEED, 31'h2AAA_AAAA);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, '0);
    repeat (4) send_request(OP_DRAW, 31'($urandom));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      seed = 31'($urandom);
      case ($urandom_range(0, 19))
        0: offer(OP_RESEED, seed);
        1: offer(OP_RESEED, ($urandom_range(0, 1) == 0) ? '0 : '1);
        default: offer(OP_DRAW, seed);
      endcase
    end
    req.valid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (sb.expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d draws, %0d reseeds incl. zero and modulus seeds.",
             sb.checked_count, sb.draw_count, sb.reseed_count);
    $display("Random stalls on both sides plus one %0d-cycle result hold-off; %0d mismatches.",
             HOLD_CYCLES, sb.err_count);
    if (sb.err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: stall on a rotating pattern, with one long hold-off
  initial begin
    logic [15:0] stall_pattern;
    int step_count;
    bit hold_done;
    rsp.ready     = 1'b0;
    stall_pattern = '1;
    step_count    = 0;
    hold_done     = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (step_count % 40 == 0)
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        rsp.ready <= stall_pattern[step_count % 16];
        step_count++;
        @(posedge clk);
      end
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      sb.check_value(rsp.random_value);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
